FILE: hdl/registry_snapshot_parser_macros.svh
// Assertion helpers used by the snapshot parser back part.
`ifndef REGISTRY_SNAPSHOT_PARSER_MACROS_SVH
`define REGISTRY_SNAPSHOT_PARSER_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define RSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define RSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/rsp_pkg.sv
package rsp_pkg;

    localparam int MAX_DEVICES_DEF  = 32;
    localparam int CAP_SLOTS_DEF    = 16;
    localparam int HEADER_BYTES_DEF = 8;
    localparam int ROW_BYTES        = 18;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [7:0]  FORMAT_RESET = 8'd1;

    typedef enum logic [1:0] {
        REC_DEVICE = 2'd0,
        REC_CAP    = 2'd1,
        REC_STATUS = 2'd2
    } rec_type_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_FORMAT    = 3'd2,
        ST_CRC       = 3'd3,
        ST_COUNT     = 3'd4,
        ST_TRUNCATED = 3'd5,
        ST_BAD_CAP   = 3'd6
    } status_t;

    // Byte address of the format code register.
    localparam logic [1:0] REG_FORMAT_CODE = 2'd0;

    // One classified byte handed from the front part to the back part.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_xact_t;

    // Record word; all result fields together.
    typedef struct packed {
        rec_type_t   rtype;
        logic [7:0]  device_index;
        logic [7:0]  device_kind;
        logic [63:0] device_address;
        logic        relay_present;
        logic [47:0] relay_node;
        logic [7:0]  signal_level;
        logic [7:0]  capability_id;
        logic [15:0] capability_value;
        status_t     status;
        logic [31:0] epoch;
        logic [7:0]  device_count;
    } record_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] d);
        logic [15:0] c;
        c = c_in ^ {d, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: hdl/registry_snapshot_parser.sv
// Channel   | Direction | Handshake            | Payload
// input     | in        | push / full          | data_byte, last_byte
// results   | out       | pop / empty          | record_type .. device_count
// config    | in        | psel/penable/pready  | format_code at address 0
// One byte per cycle unless the front queue fills or the back part stalls. A last
// byte that also completes a device or capability record yields two records, and the
// second waits in the hold register while the back part takes no byte.
// A last byte waits until both result slots are free, any other byte until one is.
// Reset (rst_n low, asynchronous) empties both queues and clears all run state.
module registry_snapshot_parser #(
    parameter int MAX_DEVICES  = rsp_pkg::MAX_DEVICES_DEF,
    parameter int CAP_SLOTS    = rsp_pkg::CAP_SLOTS_DEF,
    parameter int HEADER_BYTES = rsp_pkg::HEADER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        pop,
    output logic        empty,
    output logic [1:0]  record_type,
    output logic [7:0]  device_index,
    output logic [7:0]  device_kind,
    output logic [63:0] device_address,
    output logic        relay_present,
    output logic [47:0] relay_node,
    output logic signed [7:0]  signal_level,
    output logic [7:0]  capability_id,
    output logic signed [15:0] capability_value,
    output logic [2:0]  status,
    output logic [31:0] epoch,
    output logic [7:0]  device_count
);
    import rsp_pkg::*;

    logic [7:0]  fmt_reg, fmt_next;
    logic        q_empty, take, rec_wr;
    logic [8:0]  q_bits;
    byte_xact_t  q_xact;
    record_t     rec, head;
    logic [1:0]  rec_free;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_FORMAT_CODE) ? {24'd0, fmt_reg} : 32'd0;

    always_comb
    begin
        fmt_next = fmt_reg;
        if (psel && penable && pwrite && pready && paddr == REG_FORMAT_CODE)
            fmt_next = pwdata[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= FORMAT_RESET;
        else
            fmt_reg <= fmt_next;
    end

    rsp_fifo #(.WIDTH(9), .DEPTH(2)) u_front (
        .clk(clk), .rst_n(rst_n),
        .wr_en(push), .wr_data({data_byte, last_byte}), .full(full),
        .rd_en(take), .rd_data(q_bits), .empty(q_empty)
    );

    assign q_xact = byte_xact_t'(q_bits);

    rsp_back #(.MAX_DEVICES(MAX_DEVICES), .CAP_SLOTS(CAP_SLOTS),
               .HEADER_BYTES(HEADER_BYTES)) u_back (
        .clk(clk), .rst_n(rst_n), .format_code(fmt_reg),
        .in_valid(!q_empty), .in_xact(q_xact), .in_take(take),
        .rec_wr(rec_wr), .rec_data(rec), .rec_free(rec_free)
    );

    rsp_out u_out (
        .clk(clk), .rst_n(rst_n), .rec_wr(rec_wr), .rec_data(rec),
        .rec_free(rec_free), .pop(pop), .empty(empty), .head(head)
    );

    assign record_type      = head.rtype;
    assign device_index     = head.device_index;
    assign device_kind      = head.device_kind;
    assign device_address   = head.device_address;
    assign relay_present    = head.relay_present;
    assign relay_node       = head.relay_node;
    assign signal_level     = head.signal_level;
    assign capability_id    = head.capability_id;
    assign capability_value = head.capability_value;
    assign status           = head.status;
    assign epoch            = head.epoch;
    assign device_count     = head.device_count;
endmodule

FILE: hdl/rsp_fifo.sv
module rsp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      count_reg;

    logic do_wr, do_rd;
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign full  = (count_reg == (AW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (AW+1)'(do_wr) - (AW+1)'(do_rd);
        end
    end
endmodule

FILE: hdl/rsp_back.sv
module rsp_back #(
    parameter int MAX_DEVICES  = rsp_pkg::MAX_DEVICES_DEF,
    parameter int CAP_SLOTS    = rsp_pkg::CAP_SLOTS_DEF,
    parameter int HEADER_BYTES = rsp_pkg::HEADER_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          format_code,
    input  logic                in_valid,
    input  rsp_pkg::byte_xact_t in_xact,
    output logic                in_take,
    output logic                rec_wr,
    output rsp_pkg::record_t    rec_data,
    input  logic [1:0]          rec_free
);
    import rsp_pkg::*;
`include "registry_snapshot_parser_macros.svh"

    localparam int PW = $clog2(HEADER_BYTES + 1);

    logic [PW-1:0] pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next, scrc_reg, scrc_next;
    logic [31:0] epoch_reg, epoch_next;
    logic [7:0]  count_reg, count_next, rows_reg, rows_next, caps_reg, caps_next;
    logic [4:0]  phase_reg, phase_next;
    logic [1:0]  tph_reg, tph_next;
    logic [63:0] addr_reg, addr_next, aux_reg, aux_next;
    logic [15:0] pend_reg, pend_next;
    status_t     err_reg, err_next;
    logic [7:0]  fmt_reg, fmt_next;
    logic        via_reg, via_next, bad_reg, bad_next;
    logic        hold_reg, hold_next;
    record_t     hold_rec_reg, hold_rec_next;

    logic       ok_in;
    logic [7:0] d;
    record_t    r0, r1;
    logic       v0, v1;
    status_t    st;
    logic [15:0] crc_new;

    // A transaction is taken only if both possible records fit downstream; a second
    // record waits in the hold register.
    assign in_take = !hold_reg && (rec_free == 2'd2 || (rec_free == 2'd1 && !in_xact.last));
    assign ok_in   = in_valid && in_take;
    assign d       = in_xact.data;
    assign crc_new = crc_byte(crc_reg, d);

    always_comb
    begin
        pos_next = pos_reg; crc_next = crc_reg; scrc_next = scrc_reg;
        epoch_next = epoch_reg; count_next = count_reg; rows_next = rows_reg;
        caps_next = caps_reg; phase_next = phase_reg; tph_next = tph_reg;
        addr_next = addr_reg; aux_next = aux_reg; pend_next = pend_reg;
        err_next = err_reg; fmt_next = fmt_reg; via_next = via_reg; bad_next = bad_reg;
        r0 = '0; r1 = '0; v0 = 1'b0; v1 = 1'b0; st = ST_OK;
        if (ok_in)
        begin
            if (pos_reg < PW'(HEADER_BYTES))
            begin
                pos_next = pos_reg + 1'b1;
                if (pos_reg == '0)
                begin
                    fmt_next = d; crc_next = crc_new;
                end
                else if (pos_reg == PW'(1)) scrc_next[7:0] = d;
                else if (pos_reg == PW'(2)) scrc_next[15:8] = d;
                else
                begin
                    crc_next = crc_new;
                    if (pos_reg == PW'(3)) epoch_next[7:0] = d;
                    else if (pos_reg == PW'(4)) epoch_next[15:8] = d;
                    else if (pos_reg == PW'(5)) epoch_next[23:16] = d;
                    else if (pos_reg == PW'(6)) epoch_next[31:24] = d;
                    else if (pos_reg == PW'(7)) count_next = d;
                end
            end
            else
            begin
                crc_next = crc_new;
                if (fmt_reg == format_code && {1'b0, count_reg} <= 9'(MAX_DEVICES)
                    && err_reg == ST_OK && rows_reg < count_reg)
                begin
                    if (phase_reg < 5'(ROW_BYTES))
                    begin
                        phase_next = phase_reg + 1'b1;
                        if (phase_reg == 5'd0)
                        begin
                            addr_next = '0; aux_next = {56'd0, d};
                            via_next = 1'b0; bad_next = 1'b0;
                        end
                        else if (phase_reg <= 5'd8)
                            addr_next[8*(phase_reg-5'd1) +: 8] = d;
                        else if (phase_reg == 5'd9)
                            via_next = (d != 8'd0);
                        else if (phase_reg <= 5'd16)
                            aux_next[8*(phase_reg-5'd9) +: 8] = d;
                        else
                        begin
                            caps_next = d;
                            v0 = 1'b1;
                            r0.rtype = REC_DEVICE;
                            r0.device_index = rows_reg;
                            r0.device_kind = aux_reg[7:0];
                            r0.device_address = addr_reg;
                            r0.relay_present = via_reg;
                            r0.relay_node = aux_reg[55:8];
                            r0.signal_level = aux_reg[63:56];
                            tph_next = 2'd0;
                            if (d == 8'd0)
                            begin
                                rows_next = rows_reg + 1'b1;
                                phase_next = 5'd0;
                            end
                        end
                    end
                    else if (tph_reg == 2'd0)
                    begin
                        pend_next = {8'd0, d}; tph_next = 2'd1;
                    end
                    else if (tph_reg == 2'd1)
                    begin
                        pend_next[15:8] = d; tph_next = 2'd2;
                    end
                    else
                    begin
                        tph_next = 2'd0;
                        if ({1'b0, pend_reg[7:0]} >= 9'(CAP_SLOTS))
                            bad_next = 1'b1;
                        else if (!bad_reg)
                        begin
                            v0 = 1'b1;
                            r0.rtype = REC_CAP;
                            r0.device_index = rows_reg;
                            r0.capability_id = pend_reg[7:0];
                            r0.capability_value = {d, pend_reg[15:8]};
                        end
                        caps_next = caps_reg - 1'b1;
                        if (caps_reg == 8'd1)
                        begin
                            if (bad_next) err_next = ST_BAD_CAP;
                            bad_next = 1'b0;
                            rows_next = rows_reg + 1'b1;
                            phase_next = 5'd0;
                        end
                    end
                end
            end
            if (in_xact.last)
            begin
                if (pos_next < PW'(HEADER_BYTES)) st = ST_SHORT;
                else if (fmt_reg != format_code) st = ST_FORMAT;
                else if (crc_next != scrc_reg) st = ST_CRC;
                else if ({1'b0, count_next} > 9'(MAX_DEVICES)) st = ST_COUNT;
                else if (err_next != ST_OK) st = err_next;
                else if (rows_next < count_next) st = ST_TRUNCATED;
                else st = ST_OK;
                v1 = 1'b1;
                r1.rtype = REC_STATUS;
                r1.status = st;
                r1.epoch = epoch_next;
                r1.device_count = count_next;
                pos_next = '0; crc_next = CRC_INIT; scrc_next = '0; epoch_next = '0;
                count_next = '0; rows_next = '0; caps_next = '0; phase_next = '0;
                tph_next = '0; addr_next = '0; aux_next = '0; pend_next = '0;
                err_next = ST_OK; fmt_next = '0; via_next = 1'b0; bad_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        hold_next = 1'b0;
        hold_rec_next = hold_rec_reg;
        rec_wr = 1'b0;
        rec_data = r0;
        if (hold_reg)
        begin
            rec_wr = 1'b1;
            rec_data = hold_rec_reg;
        end
        else if (v0)
        begin
            rec_wr = 1'b1;
            rec_data = r0;
            if (v1)
            begin
                hold_next = 1'b1;
                hold_rec_next = r1;
            end
        end
        else if (v1)
        begin
            rec_wr = 1'b1;
            rec_data = r1;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_rec_reg <= hold_rec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0; crc_reg <= CRC_INIT; scrc_reg <= '0; epoch_reg <= '0;
            count_reg <= '0; rows_reg <= '0; caps_reg <= '0; phase_reg <= '0;
            tph_reg <= '0; addr_reg <= '0; aux_reg <= '0; pend_reg <= '0;
            err_reg <= ST_OK; fmt_reg <= '0; via_reg <= 1'b0; bad_reg <= 1'b0;
            hold_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next; crc_reg <= crc_next; scrc_reg <= scrc_next;
            epoch_reg <= epoch_next; count_reg <= count_next; rows_reg <= rows_next;
            caps_reg <= caps_next; phase_reg <= phase_next; tph_reg <= tph_next;
            addr_reg <= addr_next; aux_reg <= aux_next; pend_reg <= pend_next;
            err_reg <= err_next; fmt_reg <= fmt_next; via_reg <= via_next;
            bad_reg <= bad_next; hold_reg <= hold_next;
        end
    end

    `RSP_ASSERT_IMP(a_hold_no_take, clk, rst_n, hold_reg, !in_take)
    `RSP_ASSERT_NEXT(a_hold_one_cycle, clk, rst_n, hold_reg, !hold_reg)
    `RSP_ASSERT_IMP(a_wr_room, clk, rst_n, rec_wr, rec_free != 2'd0)
    `RSP_ASSERT_IMP(a_phase_range, clk, rst_n, 1'b1, phase_reg <= 5'(ROW_BYTES))
endmodule

FILE: hdl/rsp_out.sv
module rsp_out (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rec_wr,
    input  rsp_pkg::record_t rec_data,
    output logic [1:0]       rec_free,
    input  logic             pop,
    output logic             empty,
    output rsp_pkg::record_t head
);
    import rsp_pkg::*;

    localparam int W = $bits(record_t);

    logic             full_unused;
    logic [W-1:0]     rd_bits;
    logic [1:0]       cnt_reg, cnt_next;

    // Two-entry result queue; the count tells the back part how much room is left.
    rsp_fifo #(.WIDTH(W), .DEPTH(2)) u_q (
        .clk(clk), .rst_n(rst_n),
        .wr_en(rec_wr), .wr_data(rec_data), .full(full_unused),
        .rd_en(pop), .rd_data(rd_bits), .empty(empty)
    );

    assign head = record_t'(rd_bits);
    assign rec_free = 2'd2 - cnt_reg;

    always_comb
    begin
        cnt_next = cnt_reg + 2'(rec_wr && !full_unused) - 2'(pop && !empty);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end
endmodule
